[src/ftlru_pkg.sv]
// Shared types, constants and helpers of the LRU flow table.
`default_nettype none
package ftlru_pkg;

  localparam int unsigned Entries = 16;
  localparam int unsigned IdxW    = $clog2(Entries);
  localparam int unsigned CntW    = $clog2(Entries + 1);

  typedef logic [IdxW-1:0] idx_t;
  typedef logic [CntW-1:0] cnt_t;

  typedef struct packed {
    logic [31:0] addr;
    logic [15:0] port;
    logic [31:0] stamp;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE
  } state_e;

  // Control from the sequencer to the scan unit.
  typedef struct packed {
    logic   clear;
    logic   step;
    idx_t   idx;
    logic   valid;
  } scan_ctl_t;

  // What the scan unit has found so far.
  typedef struct packed {
    logic have_hit;
    idx_t hit_idx;
    logic have_hole;
    idx_t hole_idx;
    idx_t old_idx;
  } scan_res_t;

  // The result port carries the low four bits of the slot number.
  function automatic logic [3:0] slot_out(input idx_t idx);
    logic [31:0] wide;
    wide = 32'(idx);
    return wide[3:0];
  endfunction

endpackage
`default_nettype wire

[src/flow_table_lru_evict_unit.sv]
// Top level of the LRU flow table: sequencer, entry RAM, valid bits and result register.
//
//  beat    | direction | handshake                   | payload
//  request | in        | in_valid_i / in_ready_o     | src_addr_i, src_port_i, now_time_i
//  result  | out       | out_valid_o / out_ready_i   | slot_index_o, was_hit_o, was_evicted_o
//
// A request passes the sequencer states in order: ST_IDLE accepts it, ST_SCAN streams the
// entry RAM through the scan unit (one entry per cycle, registered read), and ST_WRITE
// writes the chosen slot back and loads the result register.
// in_ready_o is high only while the sequencer is idle; a pending result does not block
// the next request until its write-back, which waits for the result register to drain.
// Reset clears all valid bits, so the RAM needs no clearing pass.
`default_nettype none
module flow_table_lru_evict_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [31:0] src_addr_i,
  input  wire logic [15:0] src_port_i,
  input  wire logic [31:0] now_time_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [3:0]       slot_index_o,
  output logic             was_hit_o,
  output logic             was_evicted_o
);

  localparam ftlru_pkg::cnt_t LastCnt = ftlru_pkg::CntW'(ftlru_pkg::Entries);

  ftlru_pkg::state_e    state_q, state_d;
  ftlru_pkg::cnt_t      cnt_q, cnt_d;
  logic [ftlru_pkg::Entries-1:0] valid_q, valid_d;
  logic [31:0]          addr_q, port_stamp_unused;
  logic [15:0]          port_q;
  logic [31:0]          now_q;
  logic                 out_valid_q, out_valid_d;
  logic [3:0]           slot_q;
  logic                 hit_q, evict_q;

  logic                 accept;
  logic                 load_out;
  ftlru_pkg::scan_ctl_t ctl;
  ftlru_pkg::scan_res_t res;
  ftlru_pkg::entry_t    rd_entry;
  ftlru_pkg::entry_t    wr_entry;
  ftlru_pkg::idx_t      slot;
  ftlru_pkg::idx_t      rd_idx;
  logic                 evict;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ftlru_pkg::ST_IDLE);
  assign load_out   = (state_q == ftlru_pkg::ST_WRITE) && (!out_valid_q || out_ready_i);
  assign port_stamp_unused = 32'd0;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ftlru_pkg::ST_IDLE: begin
        cnt_d = '0;
        if (accept) begin
          state_d = ftlru_pkg::ST_SCAN;
        end
      end
      ftlru_pkg::ST_SCAN: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LastCnt) begin
          state_d = ftlru_pkg::ST_WRITE;
        end
      end
      ftlru_pkg::ST_WRITE: begin
        if (load_out) begin
          state_d = ftlru_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ftlru_pkg::ST_IDLE;
      end
    endcase
  end

  // RAM data for the entry addressed last cycle arrives now, so the scan index is rd_idx minus one.
  assign rd_idx    = cnt_q[ftlru_pkg::IdxW-1:0];
  assign ctl.clear = accept;
  assign ctl.step  = (state_q == ftlru_pkg::ST_SCAN) && (cnt_q != '0);
  assign ctl.idx   = ftlru_pkg::IdxW'(cnt_q - 1'b1);
  assign ctl.valid = valid_q[ctl.idx];

  ftlru_ram #(
    .Width (ftlru_pkg::EntryW),
    .Depth (ftlru_pkg::Entries)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (load_out),
    .waddr_i (slot),
    .wdata_i (wr_entry),
    .raddr_i (rd_idx),
    .rdata_o (rd_entry)
  );

  ftlru_scan u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .entry_i    (rd_entry),
    .key_addr_i (addr_q),
    .key_port_i (port_q),
    .res_o      (res)
  );

  always_comb begin
    evict = 1'b0;
    priority if (res.have_hit) begin
      slot = res.hit_idx;
    end else if (res.have_hole) begin
      slot = res.hole_idx;
    end else begin
      slot  = res.old_idx;
      evict = 1'b1;
    end
  end

  // On a hit the stored key equals the request key, so the whole entry is rewritten.
  assign wr_entry.addr  = addr_q;
  assign wr_entry.port  = port_q;
  assign wr_entry.stamp = now_q | port_stamp_unused;

  always_comb begin
    valid_d = valid_q;
    if (load_out) begin
      valid_d[slot] = 1'b1;
    end
  end

  assign out_valid_d = load_out || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ftlru_pkg::ST_IDLE;
      cnt_q       <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      addr_q <= src_addr_i;
      port_q <= src_port_i;
      now_q  <= now_time_i;
    end
    if (load_out) begin
      slot_q  <= ftlru_pkg::slot_out(slot);
      hit_q   <= res.have_hit;
      evict_q <= evict;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign slot_index_o  = slot_q;
  assign was_hit_o     = hit_q;
  assign was_evicted_o = evict_q;

endmodule
`default_nettype wire

[src/ftlru_ram.sv]
// Generic RAM with one write port and one registered read port.
`default_nettype none
module ftlru_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

[src/ftlru_scan.sv]
// Scan unit: one key compare and one stamp compare per entry per cycle.
`default_nettype none
module ftlru_scan (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire ftlru_pkg::scan_ctl_t ctl_i,
  input  wire ftlru_pkg::entry_t  entry_i,
  input  wire logic [31:0]        key_addr_i,
  input  wire logic [15:0]        key_port_i,
  output ftlru_pkg::scan_res_t    res_o
);

  logic            have_hit_q, have_hit_d;
  logic            have_hole_q, have_hole_d;
  logic            have_old_q, have_old_d;
  ftlru_pkg::idx_t hit_idx_q, hit_idx_d;
  ftlru_pkg::idx_t hole_idx_q, hole_idx_d;
  ftlru_pkg::idx_t old_idx_q, old_idx_d;
  logic [31:0]     old_stamp_q, old_stamp_d;
  logic            key_match;
  logic            is_older;

  assign key_match = (entry_i.addr == key_addr_i) && (entry_i.port == key_port_i);
  assign is_older  = !have_old_q || (entry_i.stamp < old_stamp_q);

  always_comb begin
    have_hit_d  = have_hit_q;
    have_hole_d = have_hole_q;
    have_old_d  = have_old_q;
    hit_idx_d   = hit_idx_q;
    hole_idx_d  = hole_idx_q;
    old_idx_d   = old_idx_q;
    old_stamp_d = old_stamp_q;
    if (ctl_i.clear) begin
      have_hit_d  = 1'b0;
      have_hole_d = 1'b0;
      have_old_d  = 1'b0;
    end else if (ctl_i.step) begin
      if (ctl_i.valid) begin
        if (!have_hit_q && key_match) begin
          have_hit_d = 1'b1;
          hit_idx_d  = ctl_i.idx;
        end
        // Strict less-than keeps the lowest index on equal stamps.
        if (is_older) begin
          have_old_d  = 1'b1;
          old_idx_d   = ctl_i.idx;
          old_stamp_d = entry_i.stamp;
        end
      end else if (!have_hole_q) begin
        have_hole_d = 1'b1;
        hole_idx_d  = ctl_i.idx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_hit_q  <= 1'b0;
      have_hole_q <= 1'b0;
      have_old_q  <= 1'b0;
    end else begin
      have_hit_q  <= have_hit_d;
      have_hole_q <= have_hole_d;
      have_old_q  <= have_old_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_idx_q   <= hit_idx_d;
    hole_idx_q  <= hole_idx_d;
    old_idx_q   <= old_idx_d;
    old_stamp_q <= old_stamp_d;
  end

  assign res_o.have_hit  = have_hit_q;
  assign res_o.hit_idx   = hit_idx_q;
  assign res_o.have_hole = have_hole_q;
  assign res_o.hole_idx  = hole_idx_q;
  assign res_o.old_idx   = old_idx_q;

endmodule
`default_nettype wire

[src/ftlru_chk.sv]
// Port-level checker for the LRU flow table and its bind to the top level.
`default_nettype none
module ftlru_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic [31:0] src_addr_i,
  input wire logic [15:0] src_port_i,
  input wire logic [31:0] now_time_i,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [3:0]  slot_index_o,
  input wire logic        was_hit_o,
  input wire logic        was_evicted_o
);

  // A result beat holds until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o &&
      $stable(slot_index_o) && $stable(was_hit_o) && $stable(was_evicted_o))
    else $error("result beat changed while stalled");

  // A hit never evicts.
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(was_hit_o && was_evicted_o))
    else $error("hit and eviction flagged together");

  // The table works on one request at a time.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while busy");

  // With no result pending, none can appear in the cycle after a request is taken.
  a_no_instant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o |=> !out_valid_o)
    else $error("result appeared before the scan");

endmodule

bind flow_table_lru_evict_unit ftlru_chk u_ftlru_chk (.*);
`default_nettype wire

[tb/sv/flow_table_lru_evict_checker.sv]
// Checker for the LRU flow table: predicts each result beat and compares it.
module flow_table_lru_evict_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [31:0] src_addr_i,
  input  logic [15:0] src_port_i,
  input  logic [31:0] now_time_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [3:0]  slot_index_i,
  input  logic        was_hit_i,
  input  logic        was_evicted_i,
  output int          error_count_o,
  output int          pending_o,
  output int          hit_count_o,
  output int          fill_count_o,
  output int          evict_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Slots = ftlru_pkg::Entries;

  typedef struct packed {
    logic [3:0] slot;
    logic       hit;
    logic       evict;
  } flow_result_t;

  bit          flow_valid [Slots];
  logic [31:0] flow_addr  [Slots];
  logic [15:0] flow_port  [Slots];
  logic [31:0] flow_stamp [Slots];

  flow_result_t expected_slots_q [$];

  assign pending_o = expected_slots_q.size();

  // One pass finds the matching flow, the first free slot and the stalest slot.
  function automatic flow_result_t admit_flow(input logic [31:0] addr,
                                              input logic [15:0] port,
                                              input logic [31:0] stamp);
    flow_result_t res;
    bit           have_hit;
    bit           have_hole;
    bit           have_old;
    int           hit_idx;
    int           hole_idx;
    int           old_idx;
    logic [31:0]  old_stamp;
    int           slot;
    have_hit  = 0;
    have_hole = 0;
    have_old  = 0;
    hit_idx   = 0;
    hole_idx  = 0;
    old_idx   = 0;
    old_stamp = '0;
    res       = '0;
    for (int i = 0; i < Slots; i++) begin
      if (flow_valid[i]) begin
        if (!have_hit && flow_addr[i] == addr && flow_port[i] == port) begin
          have_hit = 1;
          hit_idx  = i;
        end
        if (!have_old || flow_stamp[i] < old_stamp) begin
          have_old  = 1;
          old_idx   = i;
          old_stamp = flow_stamp[i];
        end
      end else if (!have_hole) begin
        have_hole = 1;
        hole_idx  = i;
      end
    end
    if (have_hit) begin
      slot    = hit_idx;
      res.hit = 1'b1;
    end else begin
      if (have_hole) begin
        slot = hole_idx;
      end else begin
        slot      = old_idx;
        res.evict = 1'b1;
      end
      flow_addr[slot]  = addr;
      flow_port[slot]  = port;
      flow_valid[slot] = 1'b1;
    end
    flow_stamp[slot] = stamp;
    res.slot = 4'(slot);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    flow_result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < Slots; i++) begin
        flow_valid[i] = 1'b0;
        flow_stamp[i] = '0;
      end
      expected_slots_q.delete();
      error_count_o = 0;
      hit_count_o   = 0;
      fill_count_o  = 0;
      evict_count_o = 0;
    end else begin
      // A result beat always belongs to an earlier request, so check it first.
      if (out_valid_i && out_ready_i) begin
        if (expected_slots_q.size() == 0) begin
          $display("%0t: result beat with nothing expected: slot %0d hit %0b evict %0b",
                   $time, slot_index_i, was_hit_i, was_evicted_i);
          error_count_o++;
        end else begin
          want = expected_slots_q.pop_front();
          if (slot_index_i !== want.slot) begin
            $display("%0t: slot_index expected %0d actual %0d", $time, want.slot,
                     slot_index_i);
            error_count_o++;
          end
          if (was_hit_i !== want.hit) begin
            $display("%0t: was_hit expected %0b actual %0b", $time, want.hit, was_hit_i);
            error_count_o++;
          end
          if (was_evicted_i !== want.evict) begin
            $display("%0t: was_evicted expected %0b actual %0b", $time, want.evict,
                     was_evicted_i);
            error_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        want = admit_flow(src_addr_i, src_port_i, now_time_i);
        if (want.hit) hit_count_o++;
        else if (want.evict) evict_count_o++;
        else fill_count_o++;
        expected_slots_q.push_back(want);
      end
    end
  end

endmodule

[tb/sv/tb_flow_table_lru_evict_unit.sv]
// Testbench top for the LRU flow table: clock, reset, request stimulus and verdict.
module tb_flow_table_lru_evict_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int StallLimit = 4000;
  localparam int DrainCycles = 40;
  localparam int PhaseItems = 200;
  localparam int Phases = 8;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [31:0] src_addr_i;
  logic [15:0] src_port_i;
  logic [31:0] now_time_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [3:0]  slot_index_o;
  logic        was_hit_o;
  logic        was_evicted_o;

  int error_count;
  int pending;
  int hit_count;
  int fill_count;
  int evict_count;
  int stall_cycles;
  bit no_idle;

  logic [31:0] key_addr [64];
  logic [15:0] key_port [64];
  logic [31:0] clock_stamp;

  flow_table_lru_evict_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .src_addr_i    (src_addr_i),
    .src_port_i    (src_port_i),
    .now_time_i    (now_time_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .slot_index_o  (slot_index_o),
    .was_hit_o     (was_hit_o),
    .was_evicted_o (was_evicted_o)
  );

  flow_table_lru_evict_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .src_addr_i    (src_addr_i),
    .src_port_i    (src_port_i),
    .now_time_i    (now_time_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .slot_index_i  (slot_index_o),
    .was_hit_i     (was_hit_o),
    .was_evicted_i (was_evicted_o),
    .error_count_o (error_count),
    .pending_o     (pending),
    .hit_count_o   (hit_count),
    .fill_count_o  (fill_count),
    .evict_count_o (evict_count)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    if (!rst_ni) out_ready_i = 1'b0;
    else out_ready_i = no_idle || ($urandom_range(99) >= 17);
  end

  // The watchdog only advances while neither channel moves a beat.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("%0t: no beat for %0d cycles, %0d results outstanding", $time,
                 StallLimit, pending);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_flow(input logic [31:0] addr, input logic [15:0] port,
                           input logic [31:0] stamp);
    if (!no_idle && $urandom_range(99) < 17) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    src_addr_i = addr;
    src_port_i = port;
    now_time_i = stamp;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] next_stamp();
    int roll;
    roll = $urandom_range(99);
    if (roll < 3) return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
    if (roll < 8) return $urandom;
    // A zero step leaves equal stamps, so ties among the oldest slots show up.
    clock_stamp = clock_stamp + $urandom_range(0, 3);
    return clock_stamp;
  endfunction

  initial begin
    int pool_size [Phases];
    int pick;
    pool_size = '{4, 12, 16, 17, 24, 40, 8, 64};
    stall_cycles = 0;
    no_idle      = 1'b0;
    clock_stamp  = 32'h100;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    src_addr_i   = '0;
    src_port_i   = '0;
    now_time_i   = '0;
    out_ready_i  = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Fill the empty table, with the field extremes among the keys.
    // The third beat repeats the first key and refreshes it.
    send_flow(32'h0, 16'h0, 32'h0);
    send_flow(32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_flow(32'h0, 16'h0, 32'd5);
    send_flow(32'h0, 16'hFFFF, 32'h0);
    send_flow(32'hFFFF_FFFF, 16'h0, 32'h0);
    for (int i = 4; i < ftlru_pkg::Entries; i++) begin
      send_flow(32'h0A00_0000 + i, 16'(1000 + i), 32'd7);
    end
    // Full table: two misses evict the tied zero-stamp slots, lowest first.
    send_flow(32'hC0A8_0001, 16'd53, 32'd9);
    send_flow(32'hC0A8_0002, 16'd53, 32'd9);
    // Refresh with an older stamp makes that slot the next victim.
    send_flow(32'hFFFF_FFFF, 16'hFFFF, 32'd1);
    send_flow(32'hC0A8_0003, 16'd80, 32'd10);
    send_flow(32'h0A00_0005, 16'd1005, 32'd11);
    send_flow(32'h5555_AAAA, 16'h5A5A, 32'd12);

    // Random part: each phase draws most keys from a fresh pool, whose size
    // relative to the table decides the mix of hits and evictions.
    for (int ph = 0; ph < Phases; ph++) begin
      for (int k = 0; k < pool_size[ph]; k++) begin
        key_addr[k] = (k > 0 && $urandom_range(3) == 0) ? key_addr[k-1] : $urandom;
        key_port[k] = (k > 0 && $urandom_range(5) == 0) ? key_port[k-1]
                                                        : 16'($urandom_range(65535));
      end
      no_idle = (ph == 3);
      for (int n = 0; n < PhaseItems; n++) begin
        if ($urandom_range(9) == 0) begin
          send_flow($urandom, 16'($urandom_range(65535)), next_stamp());
        end else begin
          pick = $urandom_range(pool_size[ph] - 1);
          send_flow(key_addr[pick], key_port[pick], next_stamp());
        end
      end
    end
    no_idle    = 1'b0;
    in_valid_i = 1'b0;

    wait (pending == 0);
    repeat (DrainCycles) @(posedge clk_i);
    $display("Covered %0d lookups: %0d hits, %0d fills of free slots, %0d evictions.",
             hit_count + fill_count + evict_count, hit_count, fill_count, evict_count);
    $display("Stimulus mixed pools of 4 to 64 flows with tied, wrapped and extreme stamps.");
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
